@@ rtl/xcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// xcpd_pkg: shared definitions for the checksum package deframer
// Sizes, header constants, parse phases, verdict codes and register indexes.
// ----------------------------------------------------------------------------
package xcpd_pkg;

	// Secret key and one-time key sizes.
	localparam int SECRET_BYTES = 32;
	localparam int SECRET_AW    = $clog2(SECRET_BYTES);
	localparam int SECRET_LW    = SECRET_AW + 1;
	localparam int SECRET_WORDS = SECRET_BYTES / 8;
	localparam int KEY_BYTES    = 64;
	localparam int KEY_AW       = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	// Header field values.
	localparam logic [31:0] VERSION_VALUE = 32'd1;
	localparam logic [31:0] KEY_SIZE_VALUE = 32'(KEY_BYTES);
	localparam logic [31:0] MIN_CONTENT = 32'd4;
	localparam logic [31:0] WORD_LAST_BYTE = 32'd3;
	localparam logic [31:0] TAG_LAST_BYTE = 32'd4;
	localparam logic [31:0] KEY_LAST_BYTE = 32'(KEY_BYTES - 1);

	// Configuration register indexes.
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_SECRET_LENGTH = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_SECRET_WORD0  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SECRET_WORD1  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SECRET_WORD2  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_SECRET_WORD3  = 3'd4;

	// Parse phases of one package.
	typedef enum logic [2:0] {
		PH_VERSION,
		PH_TAG,
		PH_KEYSIZE,
		PH_KEY,
		PH_LENGTH,
		PH_CONTENT,
		PH_TRAILER,
		PH_DRAIN
	} phase_t;

	// Verdict codes; ST_OK also means no failure recorded.
	typedef enum logic [2:0] {
		ST_OK,
		ST_OUTER,
		ST_VERSION,
		ST_TAG,
		ST_KEYSIZE,
		ST_TRUNC,
		ST_SHORT,
		ST_INNER
	} status_t;

	// Expected tag characters, in arrival order.
	function automatic logic [7:0] tag_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h53;
			3'd1: c = 8'h59;
			3'd2: c = 8'h43;
			3'd3: c = 8'h4E;
			3'd4: c = 8'h50;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Sign extension of one byte to the sum width.
	function automatic logic [31:0] sext8(input logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

endpackage

@@ rtl/xcpd_ram.sv @@
// ----------------------------------------------------------------------------
// xcpd_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module xcpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, loaded every cycle.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/xor_checksum_packet_deframer_core.sv @@
// ----------------------------------------------------------------------------
// xor_checksum_packet_deframer_core: XOR-wrapped package deframer
// Strips the secret-key XOR, checks the header, stores the one-time key,
// decodes content words and reports a verdict at the end of each package.
// ----------------------------------------------------------------------------
// Usage:
// Package bytes enter on the in channel, one word per handshake, with
// is_last marking the final byte. Each accepted word is held in the input
// register and parsed from there into the result register, which offers it
// on the out channel. The block takes one input word every cycle while the
// receiver does not stall; the limit is the single parse step and the
// one-time key memory read, which is prefetched one word ahead. Content
// words give kind 0 with the decoded byte; the last byte gives one kind 1
// word with the verdict in status. Header bytes and the trailer give no
// result. The cfg channel writes secret_length (index 0) and
// secret_word0..3 (indexes 1 to 4); it is always ready. The user must use
// it only while idle; the block itself does not enforce this. Reset clears
// the configuration and the parse state; the one-time key memory is not
// cleared. When the receiver stalls, the result register and the input
// register both hold and in_ready drops until space frees up.
// ----------------------------------------------------------------------------
module xor_checksum_packet_deframer_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 in_byte,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       kind,
	output logic [7:0]                 content_byte,
	output logic [2:0]                 status,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [xcpd_pkg::CFG_IW-1:0] cfg_index,
	input  logic [63:0]                cfg_data
);
	import xcpd_pkg::*;

	// Configuration registers.
	logic [5:0]                secret_length_q;
	logic [SECRET_BYTES*8-1:0] secret_q;

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state.
	phase_t                phase_q, phase_n;
	logic [SECRET_AW-1:0]  secret_pos_q, secret_pos_n;
	logic [31:0]           byte_count_q, byte_count_n;
	logic [31:0]           field_q, field_n;
	status_t               fail_q, fail_n;
	logic [31:0]           outer_sum_q, outer_sum_n;
	logic [31:0]           outer_tail_q, outer_tail_n;
	logic [31:0]           content_length_q, content_length_n;
	logic [31:0]           inner_sum_q, inner_sum_n;
	logic [31:0]           inner_tail_q, inner_tail_n;
	logic [KEY_AW-1:0]     key_pos_q, key_pos_n;

	// Result register.
	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] content_byte_q;
	status_t    status_q;

	// Per-word working signals.
	logic                 advance;
	logic                 emit;
	logic                 res_kind;
	logic [7:0]           res_byte;
	status_t              res_status;
	logic [SECRET_LW-1:0] len_eff;
	logic [SECRET_AW-1:0] pos_use;
	logic [7:0]           secret_byte;
	logic [7:0]           plain;
	logic [31:0]          cnt_inc;
	logic [31:0]          field_d;
	logic [7:0]           dec;
	logic                 key_we;
	logic [KEY_AW-1:0]    key_rd_addr;
	logic [7:0]           key_rd_data;

	// Handshakes: the parse step runs when the result register has room.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign content_byte = content_byte_q;
	assign status       = status_q;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_length_q <= '0;
			secret_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SECRET_LENGTH: secret_length_q <= cfg_data[5:0];
				CFG_SECRET_WORD0:  secret_q[0*64 +: 64] <= cfg_data;
				CFG_SECRET_WORD1:  secret_q[1*64 +: 64] <= cfg_data;
				CFG_SECRET_WORD2:  secret_q[2*64 +: 64] <= cfg_data;
				CFG_SECRET_WORD3:  secret_q[3*64 +: 64] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= is_last;
		end
	end

	// Outer secret-key XOR with the rolling key position.
	always_comb begin
		if (secret_length_q > 6'(SECRET_BYTES)) begin
			len_eff = SECRET_LW'(SECRET_BYTES);
		end else begin
			len_eff = SECRET_LW'(secret_length_q);
		end
		if ({1'b0, secret_pos_q} >= len_eff) begin
			pos_use = '0;
		end else begin
			pos_use = secret_pos_q;
		end
		secret_byte = secret_q[{pos_use, 3'b000} +: 8];
		if (len_eff == '0) begin
			plain        = byte_s1;
			secret_pos_n = secret_pos_q;
		end else begin
			plain = byte_s1 ^ secret_byte;
			if (({1'b0, pos_use} + SECRET_LW'(1)) >= len_eff) begin
				secret_pos_n = '0;
			end else begin
				secret_pos_n = pos_use + SECRET_AW'(1);
			end
		end
	end

	// Parse step: next state and the result word for the byte in the input register.
	always_comb begin
		phase_n          = phase_q;
		byte_count_n     = byte_count_q;
		field_n          = field_q;
		fail_n           = fail_q;
		content_length_n = content_length_q;
		inner_sum_n      = inner_sum_q;
		inner_tail_n     = inner_tail_q;
		key_pos_n        = key_pos_q;
		emit             = 1'b0;
		res_kind         = 1'b0;
		res_byte         = 8'h00;
		res_status       = ST_OK;
		key_we           = 1'b0;
		dec              = plain ^ key_rd_data;
		cnt_inc          = byte_count_q + 32'd1;
		field_d          = field_q | ({24'h000000, plain} << {byte_count_q[1:0], 3'b000});
		outer_sum_n      = outer_sum_q + sext8(outer_tail_q[7:0]);
		outer_tail_n     = {plain, outer_tail_q[31:8]};

		if (last_s1) begin
			// Verdict, then the whole package state starts over.
			emit     = 1'b1;
			res_kind = 1'b1;
			if (phase_q == PH_VERSION && byte_count_q < WORD_LAST_BYTE) begin
				res_status = ST_TRUNC;
			end else if (outer_sum_n != outer_tail_n) begin
				res_status = ST_OUTER;
			end else if (fail_q != ST_OK) begin
				res_status = fail_q;
			end else if (phase_q != PH_TRAILER) begin
				res_status = ST_TRUNC;
			end else if (inner_sum_q != inner_tail_q) begin
				res_status = ST_INNER;
			end else begin
				res_status = ST_OK;
			end
			phase_n          = PH_VERSION;
			byte_count_n     = '0;
			field_n          = '0;
			fail_n           = ST_OK;
			outer_sum_n      = '0;
			outer_tail_n     = '0;
			content_length_n = '0;
			inner_sum_n      = '0;
			inner_tail_n     = '0;
			key_pos_n        = '0;
		end else begin
			case (phase_q)
				PH_VERSION: begin
					byte_count_n = cnt_inc;
					field_n      = field_d;
					if (byte_count_q == WORD_LAST_BYTE) begin
						if (field_d != VERSION_VALUE) begin
							fail_n  = ST_VERSION;
							phase_n = PH_DRAIN;
						end else begin
							phase_n      = PH_TAG;
							byte_count_n = '0;
							field_n      = '0;
						end
					end
				end
				PH_TAG: begin
					if (plain != tag_char(byte_count_q[2:0])) begin
						fail_n  = ST_TAG;
						phase_n = PH_DRAIN;
					end else if (byte_count_q == TAG_LAST_BYTE) begin
						phase_n      = PH_KEYSIZE;
						byte_count_n = '0;
						field_n      = '0;
					end else begin
						byte_count_n = cnt_inc;
					end
				end
				PH_KEYSIZE: begin
					byte_count_n = cnt_inc;
					field_n      = field_d;
					if (byte_count_q == WORD_LAST_BYTE) begin
						if (field_d != KEY_SIZE_VALUE) begin
							fail_n  = ST_KEYSIZE;
							phase_n = PH_DRAIN;
						end else begin
							phase_n      = PH_KEY;
							byte_count_n = '0;
							field_n      = '0;
						end
					end
				end
				PH_KEY: begin
					key_we       = 1'b1;
					byte_count_n = cnt_inc;
					if (byte_count_q == KEY_LAST_BYTE) begin
						phase_n      = PH_LENGTH;
						byte_count_n = '0;
						field_n      = '0;
					end
				end
				PH_LENGTH: begin
					byte_count_n = cnt_inc;
					field_n      = field_d;
					if (byte_count_q == WORD_LAST_BYTE) begin
						content_length_n = field_d;
						if (field_d[31] || field_d < MIN_CONTENT) begin
							fail_n  = ST_SHORT;
							phase_n = PH_DRAIN;
						end else begin
							phase_n      = PH_CONTENT;
							byte_count_n = '0;
							field_n      = '0;
							key_pos_n    = '0;
						end
					end
				end
				PH_CONTENT: begin
					emit     = 1'b1;
					res_byte = dec;
					if (key_pos_q == KEY_AW'(KEY_BYTES - 1)) begin
						key_pos_n = '0;
					end else begin
						key_pos_n = key_pos_q + KEY_AW'(1);
					end
					inner_sum_n  = inner_sum_q + sext8(inner_tail_q[7:0]);
					inner_tail_n = {dec, inner_tail_q[31:8]};
					byte_count_n = cnt_inc;
					if (cnt_inc >= content_length_q) begin
						phase_n = PH_TRAILER;
					end
				end
				default: ;
			endcase
		end
	end

	// One-time key store; the read runs one word ahead of the content.
	assign key_rd_addr = advance ? key_pos_n : key_pos_q;

	xcpd_ram #(
		.WIDTH(8),
		.DEPTH(KEY_BYTES)
	) u_key_ram (
		.clk    (clk),
		.wr_en  (advance && key_we),
		.wr_addr(byte_count_q[KEY_AW-1:0]),
		.wr_data(plain),
		.rd_addr(key_rd_addr),
		.rd_data(key_rd_data)
	);

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_VERSION;
			secret_pos_q     <= '0;
			byte_count_q     <= '0;
			field_q          <= '0;
			fail_q           <= ST_OK;
			outer_sum_q      <= '0;
			outer_tail_q     <= '0;
			content_length_q <= '0;
			inner_sum_q      <= '0;
			inner_tail_q     <= '0;
			key_pos_q        <= '0;
		end else if (advance) begin
			phase_q          <= phase_n;
			secret_pos_q     <= last_s1 ? '0 : secret_pos_n;
			byte_count_q     <= byte_count_n;
			field_q          <= field_n;
			fail_q           <= fail_n;
			outer_sum_q      <= outer_sum_n;
			outer_tail_q     <= outer_tail_n;
			content_length_q <= content_length_n;
			inner_sum_q      <= inner_sum_n;
			inner_tail_q     <= inner_tail_n;
			key_pos_q        <= key_pos_n;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q         <= res_kind;
			content_byte_q <= res_byte;
			status_q       <= res_status;
		end
	end

	// A verdict always restarts the parse at the version field.
	a_verdict_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == PH_VERSION && byte_count_q == '0
			&& fail_q == ST_OK)
		else $error("package state not cleared after verdict");

	// A content byte in the parse step always produces a content word.
	a_content_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && phase_q == PH_CONTENT |=> out_valid_q && !kind_q)
		else $error("content byte did not produce a content word");

	// A recorded failure always parks the parser in the drain phase.
	a_fail_drains: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q != ST_OK |-> phase_q == PH_DRAIN)
		else $error("failure recorded outside the drain phase");

	// The key position moves only once content decoding has begun.
	a_key_pos_content: assert property (@(posedge clk) disable iff (!arst_n)
		key_pos_q != '0 |-> phase_q == PH_CONTENT || phase_q == PH_TRAILER)
		else $error("key position moved outside content");

endmodule
